// ===== hw/rtl/rhl_pkg.sv =====
// Package: shared widths, operation codes and register indexes for the ReLU layer block.
`default_nettype none

package rhl_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned OUT_W  = 56;
  localparam int unsigned HID_W  = 31;
  localparam int unsigned TERM_W = 48;
  localparam int unsigned CFG_IW = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  localparam logic [CFG_IW-1:0] REG_NODES      = 2'd0;
  localparam logic [CFG_IW-1:0] REG_OUT_WEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_OUT_BIAS   = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/rhl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rhl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic                 re_i,
  input  wire logic [AW-1:0]        raddr_i,
  output logic      [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rhl_mac.sv =====
// Two-stage multiply datapath with ReLU and saturating accumulator.
`default_nettype none

module rhl_mac
  import rhl_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     clear_i,
  input  wire logic                     valid_i,
  input  wire logic signed [DATA_W-1:0] weight_i,
  input  wire logic signed [DATA_W-1:0] bias_i,
  input  wire logic signed [DATA_W-1:0] sample_i,
  input  wire logic signed [DATA_W-1:0] out_weight_i,
  input  wire logic signed [DATA_W-1:0] out_bias_i,
  output logic                          busy_o,
  output logic             [OUT_W-1:0]  sum_o
);

  logic signed [2*DATA_W-1:0]   prod1;
  logic signed [2*DATA_W:0]     pre1;
  logic        [HID_W-1:0]      hid_d, hid_q;
  logic                         hid_vld_q;
  logic signed [TERM_W-1:0]     prod2;
  logic signed [TERM_W:0]       pre2;
  logic        [TERM_W-1:0]     term_d, term_q;
  logic                         term_vld_q;
  logic        [OUT_W:0]        acc;
  logic        [OUT_W-1:0]      sum_q;

  assign prod1 = weight_i * sample_i;
  assign pre1  = (2*DATA_W+1)'(prod1) + (2*DATA_W+1)'(bias_i);
  assign hid_d = pre1[2*DATA_W] ? '0 : pre1[HID_W-1:0];

  assign prod2  = TERM_W'($signed({1'b0, hid_q})) * TERM_W'(out_weight_i);
  assign pre2   = (TERM_W+1)'(prod2) + (TERM_W+1)'(out_bias_i);
  assign term_d = pre2[TERM_W] ? '0 : pre2[TERM_W-1:0];

  assign acc = {1'b0, sum_q} + (OUT_W+1)'(term_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hid_vld_q  <= 1'b0;
      term_vld_q <= 1'b0;
      sum_q      <= '0;
    end else begin
      hid_vld_q  <= valid_i;
      term_vld_q <= hid_vld_q;
      if (clear_i) begin
        sum_q <= '0;
      end else if (term_vld_q) begin
        sum_q <= acc[OUT_W] ? {OUT_W{1'b1}} : acc[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hid_q  <= hid_d;
    term_q <= term_d;
  end

  assign busy_o = hid_vld_q | term_vld_q;
  assign sum_o  = sum_q;

endmodule

`default_nettype wire

// ===== hw/rtl/relu_hidden_layer_forward_pass.sv =====
// Top level: node table, run sequencer and config registers of the ReLU hidden layer.
//
//  channel   direction  handshake                 payload
//  command   in         start && !busy            operation_i, node_index_i, node_weight_i,
//                                                 node_bias_i, sample_i
//  result    out        done_o (one-cycle strobe) network_output_o
//  config    in         cfg_we_i                  cfg_index_i, cfg_wdata_i
//
//  A load writes its table entry when accepted; busy stays low.
//  A run reads the table once for each node in use (count = nodes in use, capped at
//  MAX_NODES), one table read per cycle, then the two multiply stages drain before the
//  result strobe.
//  busy is high from the cycle after a run is accepted until the result strobe.
//  Reset clears config registers and control; the node table is not cleared.
//  The receiver cannot stall; each result is valid for the single done_o cycle.
`default_nettype none

module relu_hidden_layer_forward_pass
  import rhl_pkg::*;
#(
  parameter int unsigned MAX_NODES = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     operation_i,
  input  wire logic              [5:0]  node_index_i,
  input  wire logic signed [DATA_W-1:0] node_weight_i,
  input  wire logic signed [DATA_W-1:0] node_bias_i,
  input  wire logic signed [DATA_W-1:0] sample_i,
  output logic                          done_o,
  output logic             [OUT_W-1:0]  network_output_o,
  input  wire logic                     cfg_we_i,
  input  wire logic        [CFG_IW-1:0] cfg_index_i,
  input  wire logic        [DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned NW = (CW > 7) ? CW : 7;
  localparam int unsigned IW = ((AW > 6) ? AW : 6) + 1;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                     state_q;
  logic        [6:0]          nodes_q;
  logic signed [DATA_W-1:0]   out_weight_q;
  logic signed [DATA_W-1:0]   out_bias_q;
  logic signed [DATA_W-1:0]   sample_q;
  logic        [CW-1:0]       count_q;
  logic        [CW-1:0]       idx_q;
  logic                       rd_vld_q;
  logic                       done_q;
  logic        [OUT_W-1:0]    result_q;

  logic                       accept;
  logic                       load_we;
  logic        [IW-1:0]       load_idx;
  logic        [NW-1:0]       nodes_ext;
  logic        [NW-1:0]       count_sat;
  logic                       rd_en;
  logic        [2*DATA_W-1:0] rdata;
  logic                       mac_busy;
  logic        [OUT_W-1:0]    mac_sum;

  assign accept    = start && !busy;
  assign load_idx  = IW'(node_index_i);
  assign load_we   = accept && (operation_i == OP_LOAD) && (load_idx < IW'(MAX_NODES));
  assign nodes_ext = NW'(nodes_q);
  assign count_sat = (nodes_ext > NW'(MAX_NODES)) ? NW'(MAX_NODES) : nodes_ext;
  assign rd_en     = (state_q == ST_RUN) && (idx_q != count_q);

  rhl_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_NODES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (load_idx[AW-1:0]),
    .wdata_i ({node_weight_i, node_bias_i}),
    .re_i    (rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  rhl_mac u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (accept && (operation_i == OP_RUN)),
    .valid_i      (rd_vld_q),
    .weight_i     ($signed(rdata[2*DATA_W-1:DATA_W])),
    .bias_i       ($signed(rdata[DATA_W-1:0])),
    .sample_i     (sample_q),
    .out_weight_i (out_weight_q),
    .out_bias_i   (out_bias_q),
    .busy_o       (mac_busy),
    .sum_o        (mac_sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q      <= '0;
      out_weight_q <= '0;
      out_bias_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_NODES:      nodes_q      <= cfg_wdata_i[6:0];
        REG_OUT_WEIGHT: out_weight_q <= $signed(cfg_wdata_i);
        REG_OUT_BIAS:   out_bias_q   <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      rd_vld_q <= rd_en;
      done_q   <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (operation_i == OP_RUN)) begin
            state_q <= ST_RUN;
            count_q <= count_sat[CW-1:0];
            idx_q   <= '0;
          end
        end
        ST_RUN: begin
          if (rd_en) begin
            idx_q <= idx_q + CW'(1);
          end else if (!rd_vld_q && !mac_busy) begin
            done_q   <= 1'b1;
            result_q <= mac_sum;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (operation_i == OP_RUN)) begin
      sample_q <= sample_i;
    end
  end

  assign busy             = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign network_output_o = result_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a run is still active");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (operation_i == OP_RUN)) |=> busy)
    else $error("accepted run did not start");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (operation_i == OP_LOAD)) |=> (!busy && !done_o))
    else $error("load transaction caused activity");

  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (idx_q < count_q))
    else $error("table read past node count");

endmodule

`default_nettype wire
